[hw/rtl/ptd_pkg.sv]
`default_nettype none
package ptd_pkg;

  // task table size
  localparam int MAX_TASKS = 8;
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  // interrupt sources, in dispatch order
  localparam int IRQ_N = 6;

  // request codes
  localparam logic [2:0] REQ_SCAN      = 3'd0;
  localparam logic [2:0] REQ_ADD       = 3'd1;
  localparam logic [2:0] REQ_RAISE_IRQ = 3'd2;
  localparam logic [2:0] REQ_RAISE_EVT = 3'd3;
  localparam logic [2:0] REQ_WAIT      = 3'd4;

  // result kinds
  localparam logic [2:0] KIND_IRQ   = 3'd0;
  localparam logic [2:0] KIND_TASK  = 3'd1;
  localparam logic [2:0] KIND_DONE  = 3'd2;
  localparam logic [2:0] KIND_ADD   = 3'd3;
  localparam logic [2:0] KIND_WAIT  = 3'd4;
  localparam logic [2:0] KIND_RAISE = 3'd5;

  // write request into the task table
  typedef struct packed {
    logic             we_period;
    logic             we_last;
    logic [IDX_W-1:0] idx;
    logic [31:0]      period;
    logic [31:0]      last_fire;
  } tbl_wr_t;

endpackage
`default_nettype wire

[hw/rtl/ptd_if.sv]
`default_nettype none
interface ptd_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] time_value;
  logic [31:0] period;
  logic [7:0]  flag_bits;

  modport source (output valid, req_type, time_value, period, flag_bits, input ready);
  modport sink (input valid, req_type, time_value, period, flag_bits, output ready);
endinterface

interface ptd_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [2:0] which;
  logic       ok;
  logic       last;

  modport source (output valid, kind, which, ok, last, input ready);
  modport sink (input valid, kind, which, ok, last, output ready);
endinterface
`default_nettype wire

[hw/rtl/ptd_task_table.sv]
`default_nettype none
module ptd_task_table (
  input  wire logic                       clk,
  input  wire ptd_pkg::tbl_wr_t           wr,
  input  wire logic [ptd_pkg::IDX_W-1:0]  rd_idx,
  input  wire logic [31:0]                now,
  output logic                            due
);

  logic [31:0] period_mem [ptd_pkg::MAX_TASKS];
  logic [31:0] last_mem   [ptd_pkg::MAX_TASKS];
  logic [31:0] elapsed;

  always_ff @(posedge clk) begin
    if (wr.we_period) begin
      period_mem[wr.idx] <= wr.period;
    end
    if (wr.we_last) begin
      last_mem[wr.idx] <= wr.last_fire;
    end
  end

  // wrapping elapsed time against the period
  assign elapsed = now - last_mem[rd_idx];
  assign due     = (elapsed >= period_mem[rd_idx]);

endmodule
`default_nettype wire

[hw/rtl/periodic_task_dispatcher.sv]
`default_nettype none
// add, raise and wait are latched on acceptance and answered from the reply
// state through the output register; a scan walks the 6 interrupt slots, then
// one slot per task, then gives its done item.
// a scan holds the block until its done item is loaded, the sequencer
// stepping one source or task per cycle (tasks through the shared elapsed-time
// compare) unless a pending item waits on an rsp stall; idle takes new requests.
// reset: task table empty, pending interrupt and event flags cleared, no item pending
module periodic_task_dispatcher (
  input  wire logic  clk,
  input  wire logic  rst,
  ptd_req_if.sink    req,
  ptd_rsp_if.source  rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_IRQ,
    S_TASK,
    S_DONE,
    S_REPLY
  } state_t;

  localparam logic [2:0] IRQ_LAST = 3'(ptd_pkg::IRQ_N - 1);

  state_t state;

  // latched request
  logic [2:0]  rq_type;
  logic [31:0] rq_time;
  logic [31:0] rq_period;
  logic [7:0]  rq_bits;

  // scheduler state
  logic [ptd_pkg::CNT_W-1:0]  task_count;
  logic [ptd_pkg::IRQ_N-1:0]  pend_irq;
  logic [7:0]                 pend_evt;

  // sequencer position
  logic [2:0]                 irq_idx;
  logic [ptd_pkg::IDX_W-1:0]  tidx;

  // output register
  logic       out_valid;
  logic [2:0] out_kind;
  logic [2:0] out_which;
  logic       out_ok;
  logic       out_last;

  logic             slot_free;
  logic             out_load;
  logic             due;
  logic             room;
  logic             last_task;
  ptd_pkg::tbl_wr_t tbl_wr;

  // the output register takes a new item when empty or being drained
  assign slot_free = !out_valid || rsp.ready;
  assign room      = (task_count < ptd_pkg::CNT_W'(ptd_pkg::MAX_TASKS));
  assign last_task = ((ptd_pkg::CNT_W'(tidx) + ptd_pkg::CNT_W'(1)) == task_count);

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.kind  = out_kind;
  assign rsp.which = out_which;
  assign rsp.ok    = out_ok;
  assign rsp.last  = out_last;

  // a new item enters the output register this cycle
  always_comb begin
    case (state)
      S_IRQ: begin
        out_load = pend_irq[irq_idx] && slot_free;
      end
      S_TASK: begin
        out_load = due && slot_free;
      end
      S_DONE, S_REPLY: begin
        out_load = slot_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // table writes: the add fills a fresh entry, a fired task takes the new time
  always_comb begin
    tbl_wr.we_period = 1'b0;
    tbl_wr.we_last   = 1'b0;
    tbl_wr.idx       = tidx;
    tbl_wr.period    = rq_period;
    tbl_wr.last_fire = rq_time;
    if (state == S_TASK && due && slot_free) begin
      tbl_wr.we_last = 1'b1;
    end else if (state == S_REPLY && slot_free && rq_type == ptd_pkg::REQ_ADD && room) begin
      tbl_wr.we_period = 1'b1;
      tbl_wr.we_last   = 1'b1;
      tbl_wr.idx       = ptd_pkg::IDX_W'(task_count);
    end
  end

  // the shared compare unit: one task entry per cycle, unless a due task waits for the output slot
  ptd_task_table u_table (
    .clk    (clk),
    .wr     (tbl_wr),
    .rd_idx (tidx),
    .now    (rq_time),
    .due    (due)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      task_count <= '0;
      pend_irq   <= '0;
      pend_evt   <= '0;
      irq_idx    <= '0;
      tidx       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            rq_type   <= req.req_type;
            rq_time   <= req.time_value;
            rq_period <= req.period;
            rq_bits   <= req.flag_bits;
            irq_idx   <= '0;
            tidx      <= '0;
            case (req.req_type)
              ptd_pkg::REQ_SCAN: begin
                state <= S_IRQ;
              end
              ptd_pkg::REQ_ADD, ptd_pkg::REQ_RAISE_IRQ,
              ptd_pkg::REQ_RAISE_EVT, ptd_pkg::REQ_WAIT: begin
                state <= S_REPLY;
              end
              default: begin
                // unused codes: dropped without a result
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_IRQ: begin
          // a pending source waits for the output slot, an idle one is skipped
          if (!pend_irq[irq_idx] || slot_free) begin
            if (pend_irq[irq_idx]) begin
              out_kind           <= ptd_pkg::KIND_IRQ;
              out_which          <= irq_idx;
              out_ok             <= 1'b0;
              out_last           <= 1'b0;
              pend_irq[irq_idx]  <= 1'b0;
            end
            if (irq_idx == IRQ_LAST) begin
              state <= (task_count == '0) ? S_DONE : S_TASK;
            end else begin
              irq_idx <= irq_idx + 3'd1;
            end
          end
        end
        S_TASK: begin
          if (!due || slot_free) begin
            if (due) begin
              out_kind  <= ptd_pkg::KIND_TASK;
              out_which <= 3'(tidx);
              out_ok    <= 1'b0;
              out_last  <= 1'b0;
            end
            if (last_task) begin
              state <= S_DONE;
            end else begin
              tidx <= tidx + ptd_pkg::IDX_W'(1);
            end
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_kind  <= ptd_pkg::KIND_DONE;
            out_which <= 3'd0;
            out_ok    <= 1'b0;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_REPLY: begin
          if (slot_free) begin
            out_which <= 3'd0;
            out_last  <= 1'b1;
            case (rq_type)
              ptd_pkg::REQ_ADD: begin
                out_kind <= ptd_pkg::KIND_ADD;
                out_ok   <= room;
                if (room) begin
                  task_count <= task_count + ptd_pkg::CNT_W'(1);
                end
              end
              ptd_pkg::REQ_RAISE_IRQ: begin
                out_kind <= ptd_pkg::KIND_RAISE;
                out_ok   <= 1'b0;
                // sources above the sixth are dropped
                pend_irq <= pend_irq | rq_bits[ptd_pkg::IRQ_N-1:0];
              end
              ptd_pkg::REQ_RAISE_EVT: begin
                out_kind <= ptd_pkg::KIND_RAISE;
                out_ok   <= 1'b0;
                pend_evt <= pend_evt | rq_bits;
              end
              ptd_pkg::REQ_WAIT: begin
                out_kind <= ptd_pkg::KIND_WAIT;
                // any match clears every requested bit
                if ((pend_evt & rq_bits) != 8'd0) begin
                  pend_evt <= pend_evt & ~rq_bits;
                  out_ok   <= 1'b1;
                end else begin
                  out_ok   <= 1'b0;
                end
              end
              default: begin
                out_kind <= ptd_pkg::KIND_RAISE;
                out_ok   <= 1'b0;
              end
            endcase
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
